[rtl/srg_pkg.sv]
// Shared types, codes and helpers for the seeded 3-D region grower.
// No dependencies; every other rtl file except srg_ram imports this package.
package srg_pkg;

	localparam int DEF_MAX_X = 32;
	localparam int DEF_MAX_Y = 32;
	localparam int DEF_MAX_Z = 32;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_FILL = 2'd1;
	localparam logic [1:0] FUNC_READ = 2'd2;
	localparam logic [1:0] FUNC_NONE = 2'd3;

	localparam logic [2:0] CFG_LOWER   = 3'd0;
	localparam logic [2:0] CFG_UPPER   = 3'd1;
	localparam logic [2:0] CFG_SIZE_X  = 3'd2;
	localparam logic [2:0] CFG_SIZE_Y  = 3'd3;
	localparam logic [2:0] CFG_SIZE_Z  = 3'd4;
	localparam logic [2:0] CFG_START_X = 3'd5;
	localparam logic [2:0] CFG_START_Y = 3'd6;
	localparam logic [2:0] CFG_START_Z = 3'd7;

	typedef struct packed {
		logic       valid;
		logic [1:0] func;
		logic [7:0] value;
	} q_item_t;

	// bits needed to index m entries, never zero
	function automatic int idx_bits(input int m);
		return (m > 1) ? $clog2(m) : 1;
	endfunction

	// strict window test: lower < v < upper
	function automatic logic in_window(input logic [7:0] v, input logic [8:0] lower,
			input logic [8:0] upper);
		logic signed [9:0] sv;
		logic signed [9:0] sl;
		sv = $signed({2'b00, v});
		sl = $signed({lower[8], lower});
		return (sv > sl) && ({2'b00, v} < {1'b0, upper});
	endfunction

endpackage

[rtl/seeded_region_grow_3d_top.sv]
// Top level of the seeded 3-D region grower: front end and back end.
// Depends on srg_pkg, srg_front, srg_back (and srg_ram through srg_back).

// Requests (start high while busy low) are func 0 load, 1 fill, 2 read; func 3
// is dropped. Loads and reads stream at one request per cycle while no fill is
// running; with nothing queued ahead, the request is written to the queue,
// popped into a pending register and then raises done. A fill first clears
// the region map, one entry a cycle, all MAX_X*MAX_Y*MAX_Z entries (32768 at
// defaults), then checks the seed in S_SEED, S_SEED2 and S_SEEDCHK, pops each
// region voxel in S_POP and S_POPW, requests each neighbor position in S_NREQ
// and checks one that lies in the volume in S_NCHK, and ends in S_POP once
// the stack is empty; the registered read of the map and voxel RAMs sets this
// pace. Requests queue behind a running fill and busy rises once the four-entry
// queue is full. Busy is also high after reset, and from the cycle a size
// register is written, while the volume product settles. Results are pulsed
// for one cycle on done and cannot be held off by the receiver.
module seeded_region_grow_3d_top import srg_pkg::*; #(
	parameter int MAX_X = DEF_MAX_X,
	parameter int MAX_Y = DEF_MAX_Y,
	parameter int MAX_Z = DEF_MAX_Z
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  func,
	input  logic [7:0]  voxel_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	output logic        done,
	output logic [7:0]  out_value,
	output logic [15:0] region_count,
	output logic        last_flag
);
	localparam int CAP = MAX_X * MAX_Y * MAX_Z;
	localparam int NW  = $clog2(CAP + 1);
	localparam int EXW = $clog2(MAX_X + 1);
	localparam int EYW = $clog2(MAX_Y + 1);
	localparam int EZW = $clog2(MAX_Z + 1);

	q_item_t item;
	logic pop;
	logic [8:0] lower, upper;
	logic [EXW-1:0] ex;
	logic [EYW-1:0] ey;
	logic [EZW-1:0] ez;
	logic [NW-1:0] exy, n;
	logic [4:0] sx, sy, sz;

	srg_front #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .func(func),
		.voxel_value(voxel_value), .busy(busy), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pop(pop), .item(item), .lower(lower), .upper(upper), .ex(ex), .ey(ey),
		.ez(ez), .exy(exy), .n(n), .sx(sx), .sy(sy), .sz(sz)
	);

	srg_back #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_back (
		.clk(clk), .arst_n(arst_n), .item(item), .pop(pop), .lower(lower),
		.upper(upper), .ex(ex), .ey(ey), .ez(ez), .exy(exy), .n(n), .sx(sx),
		.sy(sy), .sz(sz), .done(done), .out_value(out_value),
		.region_count(region_count), .last_flag(last_flag)
	);
endmodule

[rtl/srg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srg_ram #(
	parameter int W = 8,
	parameter int D = 1024
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                 wdata,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                 rdata
);
	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

[rtl/srg_front.sv]
// Front end: configuration registers, derived volume dimensions, command
// accept and classify, and the command queue feeding the back end. Uses srg_pkg.
module srg_front import srg_pkg::*; #(
	parameter int MAX_X = DEF_MAX_X,
	parameter int MAX_Y = DEF_MAX_Y,
	parameter int MAX_Z = DEF_MAX_Z,
	localparam int CAP = MAX_X * MAX_Y * MAX_Z,
	localparam int NW  = $clog2(CAP + 1),
	localparam int EXW = $clog2(MAX_X + 1),
	localparam int EYW = $clog2(MAX_Y + 1),
	localparam int EZW = $clog2(MAX_Z + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [1:0]     func,
	input  logic [7:0]     voxel_value,
	output logic           busy,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [2:0]     cfg_index,
	input  logic [8:0]     cfg_data,
	input  logic           pop,
	output q_item_t        item,
	output logic [8:0]     lower,
	output logic [8:0]     upper,
	output logic [EXW-1:0] ex,
	output logic [EYW-1:0] ey,
	output logic [EZW-1:0] ez,
	output logic [NW-1:0]  exy,
	output logic [NW-1:0]  n,
	output logic [4:0]     sx,
	output logic [4:0]     sy,
	output logic [4:0]     sz
);
	localparam int QPW = idx_bits(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	logic [8:0] lower_q, upper_q;
	logic [5:0] size_x_q, size_y_q, size_z_q;
	logic [4:0] sx_q, sy_q, sz_q;
	logic [1:0] dims_cnt_q;
	logic [NW-1:0] exy_q, n_q;

	logic [1:0] qf_q [QUEUE_DEPTH];
	logic [7:0] qv_q [QUEUE_DEPTH];
	logic [QPW-1:0] wp_q, rp_q;
	logic [QCW-1:0] cnt_q;
	logic push, cfg_we, size_we;

	function automatic int clamp(input logic [5:0] s, input int cap);
		if (s == 6'd0) return 1;
		return (int'(s) > cap) ? cap : int'(s);
	endfunction

	assign ex = EXW'(clamp(size_x_q, MAX_X));
	assign ey = EYW'(clamp(size_y_q, MAX_Y));
	assign ez = EZW'(clamp(size_z_q, MAX_Z));

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign size_we   = cfg_we && (cfg_index == CFG_SIZE_X || cfg_index == CFG_SIZE_Y ||
		cfg_index == CFG_SIZE_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q  <= 9'd0;
			upper_q  <= 9'd255;
			size_x_q <= 6'd32;
			size_y_q <= 6'd32;
			size_z_q <= 6'd32;
			sx_q     <= 5'd0;
			sy_q     <= 5'd0;
			sz_q     <= 5'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOWER:   lower_q  <= cfg_data;
				CFG_UPPER:   upper_q  <= cfg_data;
				CFG_SIZE_X:  size_x_q <= cfg_data[5:0];
				CFG_SIZE_Y:  size_y_q <= cfg_data[5:0];
				CFG_SIZE_Z:  size_z_q <= cfg_data[5:0];
				CFG_START_X: sx_q     <= cfg_data[4:0];
				CFG_START_Y: sy_q     <= cfg_data[4:0];
				CFG_START_Z: sz_q     <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// two-stage product of the extents; hold off commands until it settles
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_cnt_q <= 2'd2;
		end else if (size_we) begin
			dims_cnt_q <= 2'd2;
		end else if (dims_cnt_q != 2'd0) begin
			dims_cnt_q <= dims_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		exy_q <= NW'(32'(ex) * 32'(ey));
		n_q   <= NW'(32'(exy_q) * 32'(ez));
	end

	assign busy = (cnt_q == QCW'(QUEUE_DEPTH)) || (dims_cnt_q != 2'd0) || size_we;
	// undefined function codes are dropped here and never reach the back end
	assign push = start && !busy && (func != FUNC_NONE);

	always_ff @(posedge clk) begin
		if (push) begin
			qf_q[wp_q] <= func;
			qv_q[wp_q] <= voxel_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + QPW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + QPW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

	assign item.valid = (cnt_q != '0);
	assign item.func  = qf_q[rp_q];
	assign item.value = qv_q[rp_q];

	assign lower = lower_q;
	assign upper = upper_q;
	assign exy   = exy_q;
	assign n     = n_q;
	assign sx    = sx_q;
	assign sy    = sy_q;
	assign sz    = sz_q;
endmodule

[rtl/srg_back.sv]
// Back end: executes load, read and fill requests in order. Holds the voxel,
// map and stack RAMs (srg_ram) and the fill sequencer. Uses srg_pkg.
module srg_back import srg_pkg::*; #(
	parameter int MAX_X = DEF_MAX_X,
	parameter int MAX_Y = DEF_MAX_Y,
	parameter int MAX_Z = DEF_MAX_Z,
	localparam int CAP = MAX_X * MAX_Y * MAX_Z,
	localparam int NW  = $clog2(CAP + 1),
	localparam int EXW = $clog2(MAX_X + 1),
	localparam int EYW = $clog2(MAX_Y + 1),
	localparam int EZW = $clog2(MAX_Z + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  q_item_t        item,
	output logic           pop,
	input  logic [8:0]     lower,
	input  logic [8:0]     upper,
	input  logic [EXW-1:0] ex,
	input  logic [EYW-1:0] ey,
	input  logic [EZW-1:0] ez,
	input  logic [NW-1:0]  exy,
	input  logic [NW-1:0]  n,
	input  logic [4:0]     sx,
	input  logic [4:0]     sy,
	input  logic [4:0]     sz,
	output logic           done,
	output logic [7:0]     out_value,
	output logic [15:0]    region_count,
	output logic           last_flag
);
	localparam int AW  = idx_bits(CAP);
	localparam int CXW = idx_bits(MAX_X);
	localparam int CYW = idx_bits(MAX_Y);
	localparam int CZW = idx_bits(MAX_Z);
	localparam int SW  = CZW + CYW + CXW + AW;

	typedef enum logic [3:0] {
		S_IDLE, S_CLR, S_SEED, S_SEED2, S_SEEDCHK, S_POP, S_POPW, S_NREQ, S_NCHK
	} state_t;

	state_t state_q;
	logic [AW-1:0] lp_q, rp_q, clr_q, cur_idx_q, ni_q, prod_a_q, prod_b_q;
	logic [CXW-1:0] cx_q, nx_q;
	logic [CYW-1:0] cy_q, ny_q;
	logic [CZW-1:0] cz_q, nz_q;
	logic [NW-1:0] sp_q;
	logic [15:0] grown_q;
	logic [15:0] count_q;
	logic [1:0] dxc_q, dyc_q, dzc_q;
	logic filled_q;
	logic pend_v_s1, pend_read_s1, pend_last_s1;
	logic done_q, last_q;
	logic [7:0] out_q;

	logic vw_we, sw_we, kw_we;
	logic [AW-1:0] vw_addr, vr_addr, sw_addr, sr_addr, kw_addr, kr_addr;
	logic [1:0] sw_data, st_rd;
	logic [SW-1:0] kw_data, stk_rd;
	logic [7:0] vox_rd;

	logic [AW-1:0] lp_eff, rp_eff, seed_idx, ni;
	logic lp_last, rp_last, seed_ok, nvalid, k_last;
	logic [CXW-1:0] nx;
	logic [CYW-1:0] ny;
	logic [CZW-1:0] nz;
	logic okx, oky, okz;

	srg_ram #(.W(8), .D(CAP)) u_vox (
		.clk(clk), .we(vw_we), .waddr(vw_addr), .wdata(item.value),
		.raddr(vr_addr), .rdata(vox_rd)
	);
	// bit 1 visited, bit 0 in region
	srg_ram #(.W(2), .D(CAP)) u_map (
		.clk(clk), .we(sw_we), .waddr(sw_addr), .wdata(sw_data),
		.raddr(sr_addr), .rdata(st_rd)
	);
	srg_ram #(.W(SW), .D(CAP)) u_stk (
		.clk(clk), .we(kw_we), .waddr(kw_addr), .wdata(kw_data),
		.raddr(kr_addr), .rdata(stk_rd)
	);

	assign lp_eff  = (NW'(lp_q) >= n) ? '0 : lp_q;
	assign rp_eff  = (NW'(rp_q) >= n) ? '0 : rp_q;
	assign lp_last = (NW'(lp_eff) == n - NW'(1));
	assign rp_last = (NW'(rp_eff) == n - NW'(1));
	assign pop     = item.valid && (state_q == S_IDLE);

	assign seed_ok  = (32'(sx) < 32'(ex)) && (32'(sy) < 32'(ey)) && (32'(sz) < 32'(ez));
	assign seed_idx = prod_a_q + prod_b_q + AW'(sx);

	// neighbor offset codes: 0 is minus one, 1 is zero, 2 is plus one
	always_comb begin
		okx = (dxc_q == 2'd0) ? (cx_q != '0) :
			(dxc_q == 2'd2) ? ((32'(cx_q) + 32'd1) < 32'(ex)) : 1'b1;
		oky = (dyc_q == 2'd0) ? (cy_q != '0) :
			(dyc_q == 2'd2) ? ((32'(cy_q) + 32'd1) < 32'(ey)) : 1'b1;
		okz = (dzc_q == 2'd0) ? (cz_q != '0) :
			(dzc_q == 2'd2) ? ((32'(cz_q) + 32'd1) < 32'(ez)) : 1'b1;
		nvalid = okx && oky && okz && !(dxc_q == 2'd1 && dyc_q == 2'd1 && dzc_q == 2'd1);
		nx = (dxc_q == 2'd0) ? cx_q - CXW'(1) : (dxc_q == 2'd2) ? cx_q + CXW'(1) : cx_q;
		ny = (dyc_q == 2'd0) ? cy_q - CYW'(1) : (dyc_q == 2'd2) ? cy_q + CYW'(1) : cy_q;
		nz = (dzc_q == 2'd0) ? cz_q - CZW'(1) : (dzc_q == 2'd2) ? cz_q + CZW'(1) : cz_q;
		// modular add: the result is in range whenever nvalid holds
		ni = cur_idx_q
			+ ((dxc_q == 2'd0) ? {AW{1'b1}} : (dxc_q == 2'd2) ? AW'(1) : '0)
			+ ((dyc_q == 2'd0) ? -AW'(ex) : (dyc_q == 2'd2) ? AW'(ex) : '0)
			+ ((dzc_q == 2'd0) ? -AW'(exy) : (dzc_q == 2'd2) ? AW'(exy) : '0);
		k_last = (dxc_q == 2'd2) && (dyc_q == 2'd2) && (dzc_q == 2'd2);
	end

	always_comb begin
		vw_we   = 1'b0;
		vw_addr = lp_eff;
		vr_addr = rp_eff;
		sr_addr = rp_eff;
		sw_we   = 1'b0;
		sw_addr = clr_q;
		sw_data = 2'b00;
		kw_we   = 1'b0;
		kw_addr = AW'(sp_q);
		kw_data = {nz_q, ny_q, nx_q, ni_q};
		kr_addr = AW'(sp_q - NW'(1));
		case (state_q)
			S_IDLE: begin
				vw_we = pop && (item.func == FUNC_LOAD);
			end
			S_CLR: begin
				sw_we = 1'b1;
			end
			S_SEED2: begin
				vr_addr = seed_idx;
				sw_we   = 1'b1;
				sw_addr = seed_idx;
				sw_data = 2'b10;
			end
			S_SEEDCHK: begin
				kw_we   = in_window(vox_rd, lower, upper);
				kw_addr = '0;
				kw_data = {cz_q, cy_q, cx_q, cur_idx_q};
			end
			S_POPW: begin
				sw_we   = 1'b1;
				sw_addr = stk_rd[AW-1:0];
				sw_data = 2'b11;
			end
			S_NREQ: begin
				vr_addr = ni;
				sr_addr = ni;
			end
			S_NCHK: begin
				sw_we   = !st_rd[1];
				sw_addr = ni_q;
				sw_data = 2'b10;
				kw_we   = !st_rd[1] && in_window(vox_rd, lower, upper) && (sp_q < n);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_SEED: begin
				prod_a_q <= AW'(32'(sz) * 32'(exy));
				prod_b_q <= AW'(32'(sy) * 32'(ex));
				cx_q     <= CXW'(sx);
				cy_q     <= CYW'(sy);
				cz_q     <= CZW'(sz);
			end
			S_SEED2: cur_idx_q <= seed_idx;
			S_POPW: begin
				{cz_q, cy_q, cx_q, cur_idx_q} <= stk_rd;
			end
			S_NREQ: begin
				ni_q <= ni;
				nx_q <= nx;
				ny_q <= ny;
				nz_q <= nz;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			lp_q         <= '0;
			rp_q         <= '0;
			clr_q        <= '0;
			sp_q         <= '0;
			grown_q      <= '0;
			count_q      <= '0;
			dxc_q        <= '0;
			dyc_q        <= '0;
			dzc_q        <= '0;
			filled_q     <= 1'b0;
			pend_v_s1    <= 1'b0;
			pend_read_s1 <= 1'b0;
			pend_last_s1 <= 1'b0;
			done_q       <= 1'b0;
			out_q        <= '0;
			last_q       <= 1'b0;
		end else begin
			pend_v_s1    <= 1'b0;
			pend_read_s1 <= 1'b0;
			pend_last_s1 <= 1'b0;
			done_q       <= pend_v_s1;
			out_q        <= (pend_read_s1 && filled_q && st_rd[0]) ? vox_rd : 8'd0;
			last_q       <= pend_last_s1;
			// registered each cycle alongside done so a fill popped right behind cannot clear it before done
			count_q      <= grown_q;
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						case (item.func)
							FUNC_LOAD: begin
								lp_q         <= lp_last ? '0 : lp_eff + AW'(1);
								pend_v_s1    <= 1'b1;
								pend_last_s1 <= lp_last;
							end
							FUNC_READ: begin
								rp_q         <= rp_last ? '0 : rp_eff + AW'(1);
								pend_v_s1    <= 1'b1;
								pend_read_s1 <= 1'b1;
								pend_last_s1 <= rp_last;
							end
							FUNC_FILL: begin
								rp_q     <= '0;
								sp_q     <= '0;
								grown_q  <= '0;
								clr_q    <= '0;
								filled_q <= 1'b1;
								state_q  <= S_CLR;
							end
							default: ;
						endcase
					end
				end
				// whole map is cleared, so a later size change still reads zeros
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CAP - 1)) begin
						state_q <= S_SEED;
					end
				end
				S_SEED: begin
					if (seed_ok) begin
						state_q <= S_SEED2;
					end else begin
						pend_v_s1 <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_SEED2: state_q <= S_SEEDCHK;
				S_SEEDCHK: begin
					if (in_window(vox_rd, lower, upper)) begin
						sp_q    <= NW'(1);
						state_q <= S_POP;
					end else begin
						pend_v_s1 <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_POP: begin
					if (sp_q == '0) begin
						pend_v_s1 <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						sp_q    <= sp_q - NW'(1);
						state_q <= S_POPW;
					end
				end
				S_POPW: begin
					if (grown_q != 16'hFFFF) begin
						grown_q <= grown_q + 16'd1;
					end
					dxc_q   <= '0;
					dyc_q   <= '0;
					dzc_q   <= '0;
					state_q <= S_NREQ;
				end
				S_NREQ, S_NCHK: begin
					if (state_q == S_NCHK && kw_we) begin
						sp_q <= sp_q + NW'(1);
					end
					if (state_q == S_NREQ && nvalid) begin
						state_q <= S_NCHK;
					end else if (k_last) begin
						state_q <= S_POP;
					end else begin
						state_q <= S_NREQ;
						if (dxc_q != 2'd2) begin
							dxc_q <= dxc_q + 2'd1;
						end else begin
							dxc_q <= '0;
							if (dyc_q != 2'd2) begin
								dyc_q <= dyc_q + 2'd1;
							end else begin
								dyc_q <= '0;
								dzc_q <= dzc_q + 2'd1;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done         = done_q;
	assign out_value    = out_q;
	assign region_count = count_q;
	assign last_flag    = last_q;

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n) sp_q <= n)
		else $error("stack level above volume size");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		kw_we |-> sp_q < n)
		else $error("push into full stack");
	a_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_s1 |=> done_q)
		else $error("pending request lost its result strobe");
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_s1 && !pend_read_s1 && !pend_last_s1 |=> out_value == 8'd0)
		else $error("nonzero value on load or fill result");
endmodule
